@@ sv/visible_char_escape_encoder_assert.svh @@
// Assertion macros for the visible character escape encoder.
// Included by every RTL file that carries concurrent checks; no other dependencies.
`ifndef VISIBLE_CHAR_ESCAPE_ENCODER_ASSERT_SVH
`define VISIBLE_CHAR_ESCAPE_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset
`define VCE_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Consequent that must hold in the cycle after the antecedent
`define VCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define VCE_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define VCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ sv/vce_pkg.sv @@
// Shared types and constants of the visible character escape encoder.
// No dependencies; used by vce_cfg_if and every module of the block.
package vce_pkg;

    // Longest run of characters one request can produce
    localparam int MaxRun = 8;
    localparam int CountW = $clog2(MaxRun + 1);
    localparam int IdxW   = $clog2(MaxRun);
    localparam int ColW   = 11;
    localparam int WidthW = 10;
    localparam int RegIdxW = 2;

    // Register indexes of the configuration port
    localparam logic [RegIdxW-1:0] REG_LIST_MODE     = 2'd0;
    localparam logic [RegIdxW-1:0] REG_NUMBERED_MODE = 2'd1;
    localparam logic [RegIdxW-1:0] REG_WINDOW_WIDTH  = 2'd2;

    localparam logic [WidthW-1:0] WindowWidthReset = 10'd72;

    typedef logic [CountW-1:0] t_count;
    typedef logic [ColW-1:0]   t_col;

    typedef struct packed {
        logic              list_mode;
        logic              numbered_mode;
        logic [WidthW-1:0] window_width;
    } t_cfg;

    typedef struct packed {
        logic [MaxRun-1:0][7:0] chars;
        t_count                 count;
    } t_run;

endpackage

@@ sv/vce_in_if.sv @@
// Input request channel of the encoder: one text byte with its line flags.
// Depends on nothing.
interface vce_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_line;

    modport source (output valid, data_byte, byte_present, end_of_line, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_line, output ready);
endinterface

@@ sv/vce_out_if.sv @@
// Output request channel of the encoder: one character per request.
// Depends on nothing.
interface vce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, out_char, last_of_run, input ready);
    modport sink   (input valid, out_char, last_of_run, output ready);
endinterface

@@ sv/vce_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on vce_pkg for the index width.
interface vce_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [vce_pkg::RegIdxW-1:0] index;
    logic [vce_pkg::WidthW-1:0]  wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

@@ sv/vce_cfg_regs.sv @@
// Configuration register file of the encoder (list mode, numbered mode, window width).
// Depends on vce_pkg and vce_cfg_if.
module vce_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    vce_cfg_if.sink        i_cfg,
    output vce_pkg::t_cfg  o_cfg
);

    vce_pkg::t_cfg r_cfg;

    // Always take writes; indexes beyond the list are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.list_mode     <= 1'b0;
            r_cfg.numbered_mode <= 1'b0;
            r_cfg.window_width  <= vce_pkg::WindowWidthReset;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                vce_pkg::REG_LIST_MODE:     r_cfg.list_mode     <= i_cfg.wdata[0];
                vce_pkg::REG_NUMBERED_MODE: r_cfg.numbered_mode <= i_cfg.wdata[0];
                vce_pkg::REG_WINDOW_WIDTH:  r_cfg.window_width  <= i_cfg.wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/vce_encoder.sv @@
// Input register, column tracking and escape expansion of one byte into a run
// of up to eight characters. Depends on vce_pkg, vce_in_if and the assertion header.
`include "visible_char_escape_encoder_assert.svh"
module vce_encoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    vce_in_if.sink         i_req,
    input  vce_pkg::t_cfg  i_cfg,
    output logic           o_run_valid,
    input  logic           i_run_ready,
    output vce_pkg::t_run  o_run
);

    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChNl     = 8'h0A;
    localparam logic [7:0] ChDollar = 8'h24;
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChTilde  = 8'h7E;
    localparam vce_pkg::t_col NumberedStart = vce_pkg::t_col'(8);

    // Saturating column add
    function automatic vce_pkg::t_col col_sat_add(input vce_pkg::t_col c,
                                                  input logic [1:0] inc);
        logic [vce_pkg::ColW:0] sum;
        sum = {1'b0, c} + {{(vce_pkg::ColW-1){1'b0}}, inc};
        return sum[vce_pkg::ColW] ? '1 : sum[vce_pkg::ColW-1:0];
    endfunction

    // Letter escape: {found, letter}
    function automatic logic [8:0] esc_letter(input logic [7:0] ch);
        logic [8:0] res;
        case (ch)
            8'd7:    res = {1'b1, 8'h61};
            8'd8:    res = {1'b1, 8'h62};
            8'd12:   res = {1'b1, 8'h66};
            8'd10:   res = {1'b1, 8'h6E};
            8'd13:   res = {1'b1, 8'h72};
            8'd9:    res = {1'b1, 8'h74};
            8'd11:   res = {1'b1, 8'h76};
            8'd92:   res = {1'b1, ChBslash};
            default: res = '0;
        endcase
        return res;
    endfunction

    logic          r_in_valid;
    logic [7:0]    r_data_byte;
    logic          r_byte_present;
    logic          r_end_of_line;
    vce_pkg::t_col r_column;
    logic          r_line_start;

    vce_pkg::t_col  n_column;
    vce_pkg::t_col  col_start;
    vce_pkg::t_col  col_step;
    vce_pkg::t_col  col_body;
    logic           wrap;
    logic           printable;
    logic [8:0]     esc;
    logic           empty_item;
    logic           advance;
    vce_pkg::t_count cnt;
    logic [vce_pkg::MaxRun-1:0][7:0] chars;

    // Items with neither byte nor line end are dropped without a run
    assign empty_item  = !r_byte_present && !r_end_of_line;
    assign advance     = r_in_valid && (empty_item || i_run_ready);
    assign o_run_valid = r_in_valid && !empty_item;
    assign i_req.ready = !r_in_valid || advance;

    // Capture the next request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_data_byte    <= i_req.data_byte;
            r_byte_present <= i_req.byte_present;
            r_end_of_line  <= i_req.end_of_line;
        end
    end

    // Advance the line state when a run is handed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column     <= '0;
            r_line_start <= 1'b1;
        end else if (advance && !empty_item) begin
            r_column     <= n_column;
            r_line_start <= r_end_of_line;
        end
    end

    // Expand the byte into its run of characters
    always_comb begin
        col_start = r_line_start ? (i_cfg.numbered_mode ? NumberedStart : '0) : r_column;
        col_step  = col_sat_add(col_start, 2'd1);
        wrap      = col_step > {1'b0, i_cfg.window_width};
        col_body  = wrap ? vce_pkg::t_col'(1) : col_step;
        printable = (r_data_byte >= ChSpace) && (r_data_byte <= ChTilde)
                    && (r_data_byte != ChBslash);
        esc       = esc_letter(r_data_byte);
        n_column  = col_start;
        chars     = '0;
        cnt       = '0;

        if (r_byte_present) begin
            if (!i_cfg.list_mode) begin
                chars[cnt[vce_pkg::IdxW-1:0]] = r_data_byte;
                cnt = cnt + vce_pkg::t_count'(1);
            end else begin
                if (wrap) begin
                    chars[cnt[vce_pkg::IdxW-1:0]] = ChBslash;
                    cnt = cnt + vce_pkg::t_count'(1);
                    chars[cnt[vce_pkg::IdxW-1:0]] = ChNl;
                    cnt = cnt + vce_pkg::t_count'(1);
                end
                if (printable) begin
                    chars[cnt[vce_pkg::IdxW-1:0]] = r_data_byte;
                    cnt = cnt + vce_pkg::t_count'(1);
                    n_column = col_body;
                end else begin
                    chars[cnt[vce_pkg::IdxW-1:0]] = ChBslash;
                    cnt = cnt + vce_pkg::t_count'(1);
                    if (esc[8]) begin
                        chars[cnt[vce_pkg::IdxW-1:0]] = esc[7:0];
                        cnt = cnt + vce_pkg::t_count'(1);
                        n_column = col_sat_add(col_body, 2'd1);
                    end else begin
                        chars[cnt[vce_pkg::IdxW-1:0]] = {6'b001100, r_data_byte[7:6]};
                        cnt = cnt + vce_pkg::t_count'(1);
                        chars[cnt[vce_pkg::IdxW-1:0]] = {5'b00110, r_data_byte[5:3]};
                        cnt = cnt + vce_pkg::t_count'(1);
                        chars[cnt[vce_pkg::IdxW-1:0]] = {5'b00110, r_data_byte[2:0]};
                        cnt = cnt + vce_pkg::t_count'(1);
                        n_column = col_sat_add(col_body, 2'd3);
                    end
                end
            end
        end

        // Close the line
        if (r_end_of_line) begin
            if (i_cfg.list_mode) begin
                chars[cnt[vce_pkg::IdxW-1:0]] = ChDollar;
                cnt = cnt + vce_pkg::t_count'(1);
            end
            chars[cnt[vce_pkg::IdxW-1:0]] = ChNl;
            cnt = cnt + vce_pkg::t_count'(1);
        end

        o_run.chars = chars;
        o_run.count = cnt;
    end

    `VCE_ASSERT_HOLDS(a_enc_run_size, i_clk, i_rst_n, o_run_valid |-> ((o_run.count != 0) && (o_run.count <= vce_pkg::t_count'(vce_pkg::MaxRun))), "run length out of range")
    `VCE_ASSERT_NEXT(a_enc_hold, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid, "held request lost")
    `VCE_ASSERT_NEXT(a_enc_eol, i_clk, i_rst_n, advance && r_end_of_line, r_line_start, "line start not set after line end")

endmodule

@@ sv/vce_emitter.sv @@
// Output serialiser: holds one run and hands out its characters one per cycle while the output is ready.
// Depends on vce_pkg, vce_out_if and the assertion header.
`include "visible_char_escape_encoder_assert.svh"
module vce_emitter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_run_valid,
    output logic           o_run_ready,
    input  vce_pkg::t_run  i_run,
    vce_out_if.source      o_res
);

    logic [vce_pkg::MaxRun-1:0][7:0] r_chars;
    vce_pkg::t_count                 r_left;

    logic take;
    logic last;
    logic load;

    assign last        = (r_left == vce_pkg::t_count'(1));
    assign take        = o_res.valid && o_res.ready;
    assign o_run_ready = (r_left == '0) || (last && o_res.ready);
    assign load        = i_run_valid && o_run_ready;

    assign o_res.valid       = (r_left != '0);
    assign o_res.out_char    = r_chars[0];
    assign o_res.last_of_run = last;

    // Load a fresh run or advance through the held one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (load) begin
            r_left <= i_run.count;
        end else if (take) begin
            r_left <= r_left - vce_pkg::t_count'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_chars <= i_run.chars;
        end else if (take) begin
            r_chars[vce_pkg::MaxRun-2:0] <= r_chars[vce_pkg::MaxRun-1:1];
            r_chars[vce_pkg::MaxRun-1]   <= '0;
        end
    end

    `VCE_ASSERT_NEXT(a_emit_load, i_clk, i_rst_n, load, r_left == $past(i_run.count), "run length not loaded")
    `VCE_ASSERT_NEXT(a_emit_drain, i_clk, i_rst_n, take && !last, o_res.valid, "run cut short")
    `VCE_ASSERT_NEXT(a_emit_idle, i_clk, i_rst_n, take && last && !i_run_valid, r_left == '0, "character invented after run")

endmodule

@@ sv/visible_char_escape_encoder.sv @@
// Top level of the visible character escape encoder.
// Depends on vce_pkg, the channel interfaces, vce_cfg_regs, vce_encoder and vce_emitter.
//
// Takes one text byte per request and writes its visible form, one character per output
// request. A new input request is taken every cycle while the output keeps pace; each
// character of an item's run (1 to 8: a wrap, an octal escape and a line end together make
// eight) needs its own output request, so the sustained rate is set by the output
// serialiser. The first character is offered once the request has passed the input
// register and its run has been loaded into the emitter's run register.
// Requests with neither a byte nor a line end yield nothing. Configuration writes are
// taken at once and must only be issued while no request is in flight.
module visible_char_escape_encoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vce_in_if.sink    i_req,
    vce_cfg_if.sink   i_cfg,
    vce_out_if.source o_res
);

    vce_pkg::t_cfg cfg;
    vce_pkg::t_run run;
    logic          run_valid;
    logic          run_ready;

    vce_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    vce_encoder u_encoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg       (cfg),
        .o_run_valid (run_valid),
        .i_run_ready (run_ready),
        .o_run       (run)
    );

    vce_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_valid (run_valid),
        .o_run_ready (run_ready),
        .i_run       (run),
        .o_res       (o_res)
    );

endmodule
